FILE: sv/esc_pkg.sv
// esc_pkg: shared types, constants and the microcode ROM of the symbol cipher.
// No dependencies; imported by esc_modmul and elgamal_symbol_cipher_top.
`default_nettype none

package esc_pkg;

    localparam int SYM_W  = 31;  // symbol and exponent width
    localparam int CNT_W  = 5;   // holds SYM_W
    localparam int PC_W   = 4;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_DECRYPT = 2'd1;
    localparam logic [1:0] REG_KEYBASE = 2'd2;
    localparam logic [1:0] REG_KEYEXP  = 2'd3;

    localparam logic [SYM_W-1:0] MODULUS_RST = SYM_W'(1009);
    localparam logic [SYM_W-1:0] KEYBASE_RST = SYM_W'(1);

    // jump conditions
    localparam logic [2:0] COND_NEVER    = 3'd0;
    localparam logic [2:0] COND_ALWAYS   = 3'd1;
    localparam logic [2:0] COND_P_LT2    = 3'd2;
    localparam logic [2:0] COND_CACHE_OK = 3'd3;
    localparam logic [2:0] COND_EXP_ZERO = 3'd4;
    localparam logic [2:0] COND_BIT0_CLR = 3'd5;

    // step actions
    localparam logic [3:0] ACT_NOP    = 4'd0;
    localparam logic [3:0] ACT_TAKE   = 4'd1;  // wait for and latch an input item
    localparam logic [3:0] ACT_KEYRED = 4'd2;  // base = key mod p, init fact/exp
    localparam logic [3:0] ACT_FACT   = 4'd3;  // fact = fact*base mod p
    localparam logic [3:0] ACT_SQR    = 4'd4;  // base = base*base mod p, exp >>= 1
    localparam logic [3:0] ACT_MARK   = 4'd5;  // key factor cached
    localparam logic [3:0] ACT_SYMRED = 4'd6;  // red = sym mod p
    localparam logic [3:0] ACT_PROD   = 4'd7;  // res = red*fact mod p
    localparam logic [3:0] ACT_EMIT   = 4'd8;  // load output register
    localparam logic [3:0] ACT_ZERO   = 4'd9;  // res = 0

    // if cond holds: pc = jump, no action; else run act, then pc = nxt
    typedef struct packed {
        logic [2:0]      cond;
        logic [PC_W-1:0] jump;
        logic [3:0]      act;
        logic [PC_W-1:0] nxt;
    } t_uword;

    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            4'd0:    w = '{COND_NEVER,    4'd0,  ACT_TAKE,   4'd1};
            4'd1:    w = '{COND_P_LT2,    4'd12, ACT_NOP,    4'd2};
            4'd2:    w = '{COND_CACHE_OK, 4'd9,  ACT_NOP,    4'd3};
            4'd3:    w = '{COND_NEVER,    4'd0,  ACT_KEYRED, 4'd4};
            4'd4:    w = '{COND_EXP_ZERO, 4'd8,  ACT_NOP,    4'd5};
            4'd5:    w = '{COND_BIT0_CLR, 4'd6,  ACT_FACT,   4'd6};
            4'd6:    w = '{COND_NEVER,    4'd0,  ACT_SQR,    4'd4};
            4'd8:    w = '{COND_NEVER,    4'd0,  ACT_MARK,   4'd9};
            4'd9:    w = '{COND_NEVER,    4'd0,  ACT_SYMRED, 4'd10};
            4'd10:   w = '{COND_NEVER,    4'd0,  ACT_PROD,   4'd11};
            4'd11:   w = '{COND_NEVER,    4'd0,  ACT_EMIT,   4'd0};
            4'd12:   w = '{COND_NEVER,    4'd0,  ACT_ZERO,   4'd11};
            default: w = '{COND_ALWAYS,   4'd0,  ACT_NOP,    4'd0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: sv/esc_modmul.sv
// esc_modmul: bit-serial interleaved modular multiplier, (a * x) mod p.
// Needs a < p; x is any SYM_W-bit value, scanned MSB first. Uses esc_pkg.
`default_nettype none

module esc_modmul #(
    parameter int MB = 31
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire  [MB-1:0]             i_a,
    input  wire  [esc_pkg::SYM_W-1:0] i_x,
    input  wire  [MB-1:0]             i_p,
    output logic                      o_done,
    output logic [MB-1:0]             o_res
);
    import esc_pkg::*;

    logic [MB-1:0]    r_acc;
    logic [MB-1:0]    r_a;
    logic [MB-1:0]    r_p;
    logic [SYM_W-1:0] r_x;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [MB+1:0] w_t;
    logic [MB+1:0] w_p1;
    logic [MB+1:0] w_p2;
    logic [MB-1:0] n_acc;

    // acc < p and a < p, so 2*acc + a < 3p: at most two subtractions
    always_comb begin
        w_t  = {1'b0, r_acc, 1'b0} + {2'b00, (r_x[SYM_W-1] ? r_a : MB'(0))};
        w_p1 = {2'b00, r_p};
        w_p2 = {1'b0, r_p, 1'b0};
        if (w_t >= w_p2) begin
            n_acc = MB'(w_t - w_p2);
        end else if (w_t >= w_p1) begin
            n_acc = MB'(w_t - w_p1);
        end else begin
            n_acc = MB'(w_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(SYM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_p   <= i_p;
            r_x   <= i_x;
        end else if (r_cnt != '0) begin
            r_acc <= n_acc;
            r_x   <= {r_x[SYM_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

`default_nettype wire

FILE: sv/elgamal_symbol_cipher_top.sv
// elgamal_symbol_cipher_top: per-symbol ElGamal cipher, microcoded sequencer.
// Depends on esc_pkg (microcode ROM, constants) and esc_modmul (mod multiplier).
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_symbol_in, i_last_in
//  out     | output    | o_out_valid / i_out_ready  | o_symbol_out, o_last_out
//  cfg     | input     | psel, penable, pwrite, ... | paddr, pwdata -> prdata
//
// One item at a time. With the key factor cached an item takes two reductions
// through esc_modmul and a few sequencer steps. The first item after any
// register write also rebuilds the factor: key mod p, then per exponent bit
// one or two multiplies. Reset is synchronous; no clearing pass. The output
// register lets the next item be accepted while a result waits; the
// sequencer stalls in its emit step only when a second result is ready and
// the first is still held.
`default_nettype none

module elgamal_symbol_cipher_top #(
    parameter int MODULUS_BITS = 31
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // input items
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire  [esc_pkg::SYM_W-1:0]  i_symbol_in,
    input  wire                        i_last_in,
    // result items
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic [esc_pkg::SYM_W-1:0]  o_symbol_out,
    output logic                       o_last_out,
    // configuration
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire  [esc_pkg::ADDR_W-1:0] paddr,
    input  wire  [esc_pkg::DATA_W-1:0] pwdata,
    output logic [esc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import esc_pkg::*;

    localparam int MB = MODULUS_BITS;

    // configuration registers
    logic [SYM_W-1:0] r_modulus;
    logic             r_decrypt;
    logic [SYM_W-1:0] r_key_base;
    logic [SYM_W-1:0] r_key_exp;

    // sequencer and datapath
    logic [PC_W-1:0]  r_pc;
    logic             r_mbusy;     // multiply issued, waiting for done
    logic             r_cache_ok;  // r_fact holds the key factor
    logic [SYM_W-1:0] r_sym;
    logic             r_last;
    logic [MB-1:0]    r_base;
    logic [MB-1:0]    r_fact;
    logic [SYM_W-1:0] r_exp;
    logic [MB-1:0]    r_red;
    logic [MB-1:0]    r_res;

    // output register
    logic             r_ov;
    logic [SYM_W-1:0] r_osym;
    logic             r_olast;

    t_uword           w_uw;
    logic             w_cond;
    logic             w_is_mul;
    logic             w_start;
    logic [MB-1:0]    w_p;
    logic [MB-1:0]    w_ma;
    logic [SYM_W-1:0] w_mx;
    logic             w_mdone;
    logic [MB-1:0]    w_mres;
    logic             w_cfg_wr;
    logic             w_emit;
    logic             w_take;
    logic             w_out_pop;

    assign w_p = r_modulus[MB-1:0];  // effective modulus
    assign w_uw = ucode_rom(r_pc);

    always_comb begin
        case (w_uw.cond)
            COND_NEVER:    w_cond = 1'b0;
            COND_ALWAYS:   w_cond = 1'b1;
            COND_P_LT2:    w_cond = (w_p < MB'(2));
            COND_CACHE_OK: w_cond = r_cache_ok;
            COND_EXP_ZERO: w_cond = (r_exp == '0);
            COND_BIT0_CLR: w_cond = !r_exp[0];
            default:       w_cond = 1'b0;
        endcase
    end

    assign w_is_mul = !w_cond && (w_uw.act inside {ACT_KEYRED, ACT_FACT, ACT_SQR,
                                                   ACT_SYMRED, ACT_PROD});
    assign w_start  = w_is_mul && !r_mbusy;

    // multiplier operands; a must stay below p
    always_comb begin
        case (w_uw.act)
            ACT_KEYRED: begin w_ma = MB'(1); w_mx = r_key_base; end
            ACT_FACT:   begin w_ma = r_fact; w_mx = SYM_W'(r_base); end
            ACT_SQR:    begin w_ma = r_base; w_mx = SYM_W'(r_base); end
            ACT_SYMRED: begin w_ma = MB'(1); w_mx = r_sym; end
            ACT_PROD:   begin w_ma = r_red;  w_mx = SYM_W'(r_fact); end
            default:    begin w_ma = MB'(1); w_mx = r_sym; end
        endcase
    end

    esc_modmul #(.MB(MB)) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_ma),
        .i_x     (w_mx),
        .i_p     (w_p),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    assign o_in_ready = !w_cond && (w_uw.act == ACT_TAKE);
    assign w_take     = o_in_ready && i_in_valid;
    assign w_out_pop  = r_ov && i_out_ready;
    assign w_emit     = !w_cond && (w_uw.act == ACT_EMIT) && (!r_ov || i_out_ready);
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_mbusy    <= 1'b0;
            r_cache_ok <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (w_cond) begin
                r_pc <= w_uw.jump;
            end else if (w_is_mul) begin
                if (!r_mbusy) begin
                    r_mbusy <= 1'b1;
                end else if (w_mdone) begin
                    r_mbusy <= 1'b0;
                    r_pc    <= w_uw.nxt;
                end
            end else begin
                case (w_uw.act)
                    ACT_TAKE: if (w_take) r_pc <= w_uw.nxt;
                    ACT_EMIT: if (w_emit) r_pc <= w_uw.nxt;
                    ACT_MARK: begin
                        r_cache_ok <= 1'b1;
                        r_pc       <= w_uw.nxt;
                    end
                    default:  r_pc <= w_uw.nxt;
                endcase
            end
            // any register write invalidates the cached factor
            if (w_cfg_wr) begin
                r_cache_ok <= 1'b0;
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (w_out_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sym  <= i_symbol_in;
            r_last <= i_last_in;
        end
        if (w_start && (w_uw.act == ACT_KEYRED)) begin
            r_fact <= MB'(1);
            r_exp  <= r_decrypt ? (SYM_W'(w_p) - SYM_W'(2)) : r_key_exp;
        end
        if (r_mbusy && w_mdone && !w_cond) begin
            case (w_uw.act)
                ACT_KEYRED: r_base <= w_mres;
                ACT_FACT:   r_fact <= w_mres;
                ACT_SQR: begin
                    r_base <= w_mres;
                    r_exp  <= r_exp >> 1;
                end
                ACT_SYMRED: r_red  <= w_mres;
                ACT_PROD:   r_res  <= w_mres;
                default:    ;
            endcase
        end
        if (!w_cond && (w_uw.act == ACT_ZERO)) begin
            r_res <= '0;
        end
        if (w_emit) begin
            r_osym  <= r_decrypt ? SYM_W'(r_res[7:0]) : SYM_W'(r_res);
            r_olast <= r_last;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= MODULUS_RST;
            r_decrypt  <= 1'b0;
            r_key_base <= KEYBASE_RST;
            r_key_exp  <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_MODULUS: r_modulus  <= pwdata[SYM_W-1:0];
                REG_DECRYPT: r_decrypt  <= pwdata[0];
                REG_KEYBASE: r_key_base <= pwdata[SYM_W-1:0];
                REG_KEYEXP:  r_key_exp  <= pwdata[SYM_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODULUS: prdata = DATA_W'(r_modulus);
            REG_DECRYPT: prdata = DATA_W'(r_decrypt);
            REG_KEYBASE: prdata = DATA_W'(r_key_base);
            REG_KEYEXP:  prdata = DATA_W'(r_key_exp);
            default:     prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign o_out_valid  = r_ov;
    assign o_symbol_out = r_osym;
    assign o_last_out   = r_olast;

endmodule

`default_nettype wire

FILE: verif/elgamal_symbol_cipher_top_tb.sv
`timescale 1ns / 1ps
// elgamal_symbol_cipher_top_tb: self-checking bench for the per-symbol ElGamal cipher.
// Depends on esc_pkg and elgamal_symbol_cipher_top (with its esc_modmul) only.

module elgamal_symbol_cipher_top_tb;
    import esc_pkg::*;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int DIRECTED_ROWS   = 39;
    localparam int RANDOM_PHASES   = 16;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int IDLE_SETTLE     = 8;    // cycles before a register write
    localparam int END_SETTLE      = 200;  // wait after the last result, watching for strays

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef enum logic [1:0] {
        IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
    } t_idle_mode;

    // One line of the directed table: either a register write or an item.
    // For items, 'known' says the result is typed in as 'want'; otherwise the
    // cipher predictor below supplies it.
    typedef struct packed {
        t_row_kind        kind;
        logic [1:0]       reg_idx;
        logic [31:0]      wdata;
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             known;
        logic [SYM_W-1:0] want;
    } t_stim_row;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_cipher_out;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [SYM_W-1:0]    i_symbol_in  = '0;
    logic                i_last_in    = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic [SYM_W-1:0]    o_symbol_out;
    logic                o_last_out;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    elgamal_symbol_cipher_top #(
        .MODULUS_BITS (31)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_symbol_in  (i_symbol_in),
        .i_last_in    (i_last_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_symbol_out (o_symbol_out),
        .o_last_out   (o_last_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: bench copy of the four registers, reset values
    // ------------------------------------------------------------------
    logic [SYM_W-1:0] cfg_modulus  = MODULUS_RST;
    logic             cfg_decrypt  = 1'b0;
    logic [SYM_W-1:0] cfg_key_base = KEYBASE_RST;
    logic [SYM_W-1:0] cfg_key_exp  = '0;

    t_cipher_out      pending_results[$];   // results still owed by the DUT
    int unsigned      send_idle_pct = 0;    // chance per cycle the sender idles
    int unsigned      recv_stall_pct = 0;   // chance per cycle ready is low
    int unsigned      error_count = 0;

    // base^expo mod m by square-and-multiply; m >= 2, operands below 2^31,
    // so every product fits in 62 bits
    function automatic logic [63:0] key_power(input logic [63:0] base,
                                              input logic [63:0] expo,
                                              input logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] b;
        logic [63:0] e;
        acc = 64'd1 % m;
        b   = base % m;
        e   = expo;
        while (e != 0) begin
            if (e[0])
                acc = (acc * b) % m;
            e = e >> 1;
            b = (b * b) % m;
        end
        return acc;
    endfunction

    // Cipher output for one symbol under the current register copy.
    // Decrypt multiplies by the Fermat inverse x^(p-2) and keeps one byte.
    function automatic logic [SYM_W-1:0] cipher_symbol(input logic [SYM_W-1:0] sym);
        logic [63:0] p;
        logic [63:0] factor;
        logic [63:0] prod;
        p = 64'(cfg_modulus);
        if (p < 2)
            return '0;       // degenerate modulus
        if (cfg_decrypt) begin
            factor = key_power(64'(cfg_key_base), p - 2, p);
            prod   = ((64'(sym) % p) * factor) % p;
            return SYM_W'(prod[7:0]);
        end
        factor = key_power(64'(cfg_key_base), 64'(cfg_key_exp), p);
        prod   = ((64'(sym) % p) * factor) % p;
        return prod[SYM_W-1:0];
    endfunction

    function automatic t_stim_row cfg_row(input logic [1:0] idx, input logic [31:0] value);
        t_stim_row r;
        r = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.wdata   = value;
        return r;
    endfunction

    function automatic t_stim_row item_row(input logic [SYM_W-1:0] sym, input logic last);
        t_stim_row r;
        r = '0;
        r.kind   = ROW_ITEM;
        r.symbol = sym;
        r.last   = last;
        return r;
    endfunction

    function automatic t_stim_row fixed_row(input logic [SYM_W-1:0] sym, input logic last,
                                            input logic [SYM_W-1:0] want);
        t_stim_row r;
        r = item_row(sym, last);
        r.known = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // Random symbol: mostly well formed for the current mode (a byte to
    // encrypt, a residue below p to decrypt), a quarter full-width noise.
    function automatic logic [SYM_W-1:0] pick_symbol();
        logic [31:0] r;
        r = $urandom();
        if ($urandom_range(3) == 0)
            return r[SYM_W-1:0];
        if (cfg_decrypt && cfg_modulus >= 2)
            return SYM_W'($urandom_range(32'(cfg_modulus) - 1));
        return SYM_W'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // APB write: setup phase, access until pready, then an idle gap so
    // back-to-back writes never drive the bus twice in one step. The
    // predictor copy takes the value with the same masking the register applies.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODULUS: cfg_modulus  = value[SYM_W-1:0];
            REG_DECRYPT: cfg_decrypt  = value[0];
            REG_KEYBASE: cfg_key_base = value[SYM_W-1:0];
            REG_KEYEXP:  cfg_key_exp  = value[SYM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offer one item; valid stays up until accepted. Random idle cycles go
    // in front, so back-to-back items keep valid high without a drop.
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last,
                               input logic known, input logic [SYM_W-1:0] want);
        t_cipher_out e;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_symbol_in <= sym;
        i_last_in   <= last;
        do @(posedge i_clk); while (!o_in_ready);
        e.symbol = known ? want : cipher_symbol(sym);
        e.last   = last;
        pending_results.push_back(e);
    endtask

    // Stop offering, wait for every owed result, then let the sequencer
    // settle back to its take step before the registers change.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // New key set per random phase, extremes weighted in.
    task automatic randomize_keys();
        logic [31:0] v;
        case ($urandom_range(8))
            0:       v = 32'd2;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'd251;
            3:       v = 32'd257;
            4:       v = 32'd65521;
            5:       v = 32'd1009;
            6:       v = $urandom_range(3);          // 0/1 degenerate, 2, 3
            default: v = $urandom();                 // often not prime
        endcase
        write_register(REG_MODULUS, v);
        write_register(REG_DECRYPT, $urandom());
        case ($urandom_range(3))
            0:       v = $urandom_range(1);
            1:       v = 32'(cfg_modulus) * $urandom_range(1, 3); // not invertible
            default: v = $urandom();
        endcase
        write_register(REG_KEYBASE, v);
        case ($urandom_range(3))
            0:       v = 32'd0;
            1:       v = $urandom_range(31);
            2:       v = 32'h7FFF_FFFF;
            default: v = $urandom();
        endcase
        write_register(REG_KEYEXP, v);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_cipher_out e;
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: symbol=%0d last=%0b",
                             o_symbol_out, o_last_out);
            end else begin
                e = pending_results.pop_front();
                if (o_symbol_out !== e.symbol || o_last_out !== e.last) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected symbol=%0d last=%0b, got symbol=%0d last=%0b",
                                 e.symbol, e.last, o_symbol_out, o_last_out);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed table, then random key phases
    // ------------------------------------------------------------------
    t_stim_row directed_rows [DIRECTED_ROWS];

    initial begin : stimulus
        directed_rows = '{
            // reset keys: p=1009, encrypt, base 1, exponent 0, so the factor is 1
            fixed_row(31'd0,          1'b0, 31'd0),
            fixed_row(31'd1008,       1'b1, 31'd1008),
            fixed_row(31'd1009,       1'b0, 31'd0),
            fixed_row(31'h7FFF_FFFF,  1'b1, 31'd695),   // wide symbol, no byte cut
            item_row (31'h2AAA_AAAA,  1'b0),
            // top bit of pwdata dropped: p = 2^31-1, full-width exponent
            cfg_row(REG_MODULUS, 32'hFFFF_FFFF),
            cfg_row(REG_KEYBASE, 32'd3),
            cfg_row(REG_KEYEXP,  32'h7FFF_FFFF),
            fixed_row(31'h7FFF_FFFF,  1'b0, 31'd0),
            item_row (31'h7FFF_FFFE,  1'b0),
            item_row (31'h5555_5555,  1'b1),
            // degenerate moduli give zero
            cfg_row(REG_MODULUS, 32'd1),
            fixed_row(31'h7FFF_FFFF,  1'b0, 31'd0),
            cfg_row(REG_MODULUS, 32'd0),
            fixed_row(31'h7FFF_FFFF,  1'b1, 31'd0),
            // modulus of two in decrypt: exponent p-2 is zero, factor 1
            cfg_row(REG_MODULUS, 32'd2),
            cfg_row(REG_DECRYPT, 32'd1),
            cfg_row(REG_KEYBASE, 32'd0),
            fixed_row(31'd3,          1'b0, 31'd1),
            fixed_row(31'h7FFF_FFFE,  1'b1, 31'd0),
            // key a multiple of p: no inverse, result zero
            cfg_row(REG_MODULUS, 32'd1009),
            cfg_row(REG_KEYBASE, 32'd2018),
            fixed_row(31'd500,        1'b0, 31'd0),
            // ordinary decrypt, key above p
            cfg_row(REG_KEYBASE, 32'h7FFF_FFFF),
            item_row (31'd1008,       1'b0),
            item_row (31'h7FFF_FFFF,  1'b1),
            // composite modulus, same formula
            cfg_row(REG_MODULUS, 32'd1000),
            item_row (31'd999,        1'b0),
            // only bit 0 of the mode register counts: back to encrypt
            cfg_row(REG_DECRYPT, 32'hFFFF_FFFE),
            cfg_row(REG_KEYBASE, 32'd0),
            cfg_row(REG_KEYEXP,  32'd0),
            fixed_row(31'd1234,       1'b0, 31'd234),   // 0^0 is 1
            cfg_row(REG_KEYEXP,  32'd5),
            fixed_row(31'd1234,       1'b1, 31'd0),     // 0^5 is 0
            // decrypt at the largest modulus: longest factor rebuild
            cfg_row(REG_MODULUS, 32'h7FFF_FFFF),
            cfg_row(REG_DECRYPT, 32'd1),
            cfg_row(REG_KEYBASE, 32'd2),
            item_row (31'h7FFF_FFFE,  1'b1),
            fixed_row(31'd0,          1'b0, 31'd0)
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 17;
        recv_stall_pct = 17;
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            if (directed_rows[row].kind == ROW_CFG) begin
                drain_pipeline();
                write_register(directed_rows[row].reg_idx, directed_rows[row].wdata);
            end else begin
                send_symbol(directed_rows[row].symbol, directed_rows[row].last,
                            directed_rows[row].known, directed_rows[row].want);
            end
        end

        // Random part: each phase gets fresh keys and one idle pattern, so
        // gaps land on the key rebuild as well as on cached items.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_pipeline();
            randomize_keys();
            case (t_idle_mode'(phase % 4))
                IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 49; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default:       begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_symbol(pick_symbol(), ($urandom_range(7) == 0), 1'b0, '0);
        end

        // Wait out the last results, then watch for strays.
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);

        if (error_count == 0)
            $display("elgamal_symbol_cipher_top verification clean");
        else
            $display("elgamal_symbol_cipher_top verification failed");
        $finish;
    end

    // Hard stop with a failure report if the run never finishes.
    initial begin : watchdog
        #8_000_000;
        $display("elgamal_symbol_cipher_top verification failed");
        $finish;
    end

endmodule

FILE: files.f
sv/esc_pkg.sv
sv/esc_modmul.sv
sv/elgamal_symbol_cipher_top.sv
verif/elgamal_symbol_cipher_top_tb.sv
